### sv/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its trigger
`define ASSERT_SAME(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// property holds in the cycle after its trigger
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### sv/iecb_pkg.sv
// types and constants of the in-edge csr builder
// used by in_edge_csr_builder and its testbench; no dependencies
package iecb_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;

    localparam int VTX_W   = $clog2(MAX_VERTICES);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int CNT_W   = EDGE_AW + 1;
    localparam int VC_W    = 11;
    localparam int POS_W   = 12;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 2;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_NBR    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLAT   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_INFO   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_VERTEX  = 2'd1;
    localparam logic [STAT_W-1:0] ST_POS     = 2'd2;
    localparam logic [STAT_W-1:0] ST_PHASE   = 2'd3;

    // register map
    localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 2'd0;
    localparam logic [VC_W-1:0]    VC_RESET          = VC_W'(MAX_VERTICES);

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VTX_W-1:0]  dest_vertex;
        logic [VTX_W-1:0]  source_vertex;
        logic [POS_W-1:0]  position;
    } t_req;

    typedef struct packed {
        logic [VTX_W-1:0]  neighbor;
        logic [CNT_W-1:0]  row_base;
        logic [CNT_W-1:0]  in_degree;
        logic [CNT_W-1:0]  out_degree;
        logic [STAT_W-1:0] status;
    } t_rsp;

    typedef struct packed {
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
    } t_edge;

endpackage

### sv/iecb_ram.sv
// simple dual-port ram: one write port, one registered read port
// no dependencies
module iecb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/in_edge_csr_builder.sv
// in-edge csr builder: edge store, counting sort by destination and csr queries
// S_DECODE answers phase, vertex and flat position errors; add then runs S_ADD_IN,
// S_ADD_OUT; info S_Q_BASE, S_Q_IND; neighbor also S_Q_POS, S_Q_NBR; flat S_Q_NBR;
// finish: prefix pass one vertex a cycle, then S_SC_C and S_SC_W per edge
// result strobe o_done is high for one cycle; the receiver cannot stall
// after reset busy stays high while the count memories are cleared
// depends on iecb_pkg, iecb_ram and assert_macros.svh
`include "assert_macros.svh"

module in_edge_csr_builder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  iecb_pkg::t_req                    i_req,
    output logic                              o_done,
    output iecb_pkg::t_rsp                    o_rsp,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iecb_pkg::PADDR_W-1:0]      paddr,
    input  logic [iecb_pkg::DATA_W-1:0]       pwdata,
    output logic [iecb_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int VTX_W   = iecb_pkg::VTX_W;
    localparam int EDGE_AW = iecb_pkg::EDGE_AW;
    localparam int CNT_W   = iecb_pkg::CNT_W;
    localparam int VC_W    = iecb_pkg::VC_W;
    localparam int EDGE_W  = 2 * VTX_W;

    // sequencer states
    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_ADD_IN  = 4'd3;
    localparam logic [3:0] S_ADD_OUT = 4'd4;
    localparam logic [3:0] S_PFX     = 4'd5;
    localparam logic [3:0] S_SC_C    = 4'd6;
    localparam logic [3:0] S_SC_W    = 4'd7;
    localparam logic [3:0] S_Q_BASE  = 4'd8;
    localparam logic [3:0] S_Q_IND   = 4'd9;
    localparam logic [3:0] S_Q_POS   = 4'd10;
    localparam logic [3:0] S_Q_NBR   = 4'd11;

    localparam logic [VTX_W-1:0] LAST_VTX   = VTX_W'(iecb_pkg::MAX_VERTICES - 1);
    localparam logic [CNT_W-1:0] EDGE_LIMIT = CNT_W'(iecb_pkg::MAX_EDGES);

    // control state
    logic [3:0]             r_state, n_state;
    logic                   r_built, n_built;
    logic [CNT_W-1:0]       r_edge_total, n_edge_total;
    logic [VTX_W-1:0]       r_cnt, n_cnt;
    logic [EDGE_AW-1:0]     r_eidx, n_eidx;
    logic                   r_done, n_done;
    logic [VC_W-1:0]        r_vertex_count;

    // payload state
    iecb_pkg::t_req         r_req;
    iecb_pkg::t_rsp         r_rsp, n_rsp;
    logic [CNT_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]       r_base, n_base;
    logic [CNT_W-1:0]       r_ind, n_ind;
    logic [CNT_W-1:0]       r_outd, n_outd;

    // memory ports
    logic                   row_we, row_re;
    logic [VTX_W-1:0]       row_waddr, row_raddr;
    logic [CNT_W-1:0]       row_wdata, row_rd;
    logic                   out_we, out_re;
    logic [VTX_W-1:0]       out_waddr, out_raddr;
    logic [CNT_W-1:0]       out_wdata, out_rd;
    logic                   cur_we, cur_re;
    logic [VTX_W-1:0]       cur_waddr, cur_raddr;
    logic [CNT_W-1:0]       cur_wdata, cur_rd;
    logic                   edge_we, edge_re;
    logic [EDGE_AW-1:0]     edge_waddr, edge_raddr;
    iecb_pkg::t_edge        edge_wdata, edge_rd;
    logic                   nbr_we, nbr_re;
    logic [EDGE_AW-1:0]     nbr_waddr, nbr_raddr;
    logic [VTX_W-1:0]       nbr_wdata, nbr_rd;

    // shared adder / subtractor
    logic [CNT_W-1:0]       alu_a, alu_b;
    logic                   alu_sub;
    logic [CNT_W:0]         alu_y;

    // request decode helpers
    logic [VC_W-1:0]        active_vtx;
    logic                   dst_oor, src_oor;
    logic                   cfg_wr;
    logic [CNT_W-1:0]       next_start;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= iecb_pkg::VC_RESET;
        end else if (cfg_wr && paddr == iecb_pkg::ADDR_VERTEX_COUNT) begin
            r_vertex_count <= pwdata[VC_W-1:0];
        end
    end

    assign prdata = (paddr == iecb_pkg::ADDR_VERTEX_COUNT) ?
                    iecb_pkg::DATA_W'(r_vertex_count) : '0;

    // vertex count saturates at the row count
    assign active_vtx = (r_vertex_count > VC_W'(iecb_pkg::MAX_VERTICES)) ?
                        VC_W'(iecb_pkg::MAX_VERTICES) : r_vertex_count;
    assign dst_oor = VC_W'(r_req.dest_vertex) >= active_vtx;
    assign src_oor = VC_W'(r_req.source_vertex) >= active_vtx;

    // end of the queried row: the last row ends at the edge total
    assign next_start = (r_req.dest_vertex == LAST_VTX) ? r_edge_total : row_rd;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    // in-degree counts, turned into row starts by finish
    iecb_ram #(.WIDTH(CNT_W), .DEPTH(iecb_pkg::MAX_VERTICES)) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (row_we),
        .i_waddr(row_waddr),
        .i_wdata(row_wdata),
        .i_re   (row_re),
        .i_raddr(row_raddr),
        .o_rdata(row_rd)
    );

    // out-degree counts
    iecb_ram #(.WIDTH(CNT_W), .DEPTH(iecb_pkg::MAX_VERTICES)) u_out_ram (
        .i_clk  (i_clk),
        .i_we   (out_we),
        .i_waddr(out_waddr),
        .i_wdata(out_wdata),
        .i_re   (out_re),
        .i_raddr(out_raddr),
        .o_rdata(out_rd)
    );

    // scatter cursors, only valid during and after finish
    iecb_ram #(.WIDTH(CNT_W), .DEPTH(iecb_pkg::MAX_VERTICES)) u_cur_ram (
        .i_clk  (i_clk),
        .i_we   (cur_we),
        .i_waddr(cur_waddr),
        .i_wdata(cur_wdata),
        .i_re   (cur_re),
        .i_raddr(cur_raddr),
        .o_rdata(cur_rd)
    );

    // edge store in arrival order
    iecb_ram #(.WIDTH(EDGE_W), .DEPTH(iecb_pkg::MAX_EDGES)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (edge_we),
        .i_waddr(edge_waddr),
        .i_wdata(edge_wdata),
        .i_re   (edge_re),
        .i_raddr(edge_raddr),
        .o_rdata(edge_rd)
    );

    // csr neighbor list
    iecb_ram #(.WIDTH(VTX_W), .DEPTH(iecb_pkg::MAX_EDGES)) u_nbr_ram (
        .i_clk  (i_clk),
        .i_we   (nbr_we),
        .i_waddr(nbr_waddr),
        .i_wdata(nbr_wdata),
        .i_re   (nbr_re),
        .i_raddr(nbr_raddr),
        .o_rdata(nbr_rd)
    );

    // ------------------------------------------------------------------
    // shared adder: increments, prefix sum, row length, row offset
    // ------------------------------------------------------------------
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_ADD_IN: begin
                alu_a = row_rd;
                alu_b = CNT_W'(1);
            end
            S_ADD_OUT: begin
                alu_a = out_rd;
                alu_b = CNT_W'(1);
            end
            S_PFX: begin
                alu_a = r_sum;
                alu_b = row_rd;
            end
            S_SC_W: begin
                alu_a = cur_rd;
                alu_b = CNT_W'(1);
            end
            S_Q_IND: begin
                alu_a   = next_start;
                alu_b   = r_base;
                alu_sub = 1'b1;
            end
            S_Q_POS: begin
                alu_a = r_base;
                alu_b = CNT_W'(r_req.position);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_y = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + (CNT_W + 1)'(alu_sub);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_built      = r_built;
        n_edge_total = r_edge_total;
        n_cnt        = r_cnt;
        n_eidx       = r_eidx;
        n_sum        = r_sum;
        n_base       = r_base;
        n_ind        = r_ind;
        n_outd       = r_outd;
        n_done       = 1'b0;
        n_rsp        = r_rsp;

        row_we  = 1'b0;  row_waddr  = r_cnt;  row_wdata  = '0;
        row_re  = 1'b0;  row_raddr  = r_req.dest_vertex;
        out_we  = 1'b0;  out_waddr  = r_cnt;  out_wdata  = '0;
        out_re  = 1'b0;  out_raddr  = r_req.dest_vertex;
        cur_we  = 1'b0;  cur_waddr  = r_cnt;  cur_wdata  = r_sum;
        cur_re  = 1'b0;  cur_raddr  = edge_rd.dst;
        edge_we = 1'b0;  edge_waddr = r_edge_total[EDGE_AW-1:0];
        edge_re = 1'b0;  edge_raddr = r_eidx;
        edge_wdata.src = r_req.source_vertex;
        edge_wdata.dst = r_req.dest_vertex;
        nbr_we  = 1'b0;  nbr_waddr  = cur_rd[EDGE_AW-1:0];  nbr_wdata = edge_rd.src;
        nbr_re  = 1'b0;  nbr_raddr  = r_req.position;

        unique case (r_state)
            // zero both count memories, one vertex a cycle
            S_CLR: begin
                row_we = 1'b1;
                out_we = 1'b1;
                n_cnt  = r_cnt + VTX_W'(1);
                if (r_cnt == LAST_VTX) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end

            // phase, vertex and position checks; start the first reads
            S_DECODE: begin
                n_rsp   = '0;
                n_state = S_IDLE;
                unique case (r_req.func)
                    iecb_pkg::FUNC_ADD: begin
                        if (r_built) begin
                            n_done = 1'b1;
                            n_rsp.status = iecb_pkg::ST_PHASE;
                        end else if (dst_oor || src_oor) begin
                            n_done = 1'b1;
                            n_rsp.status = iecb_pkg::ST_VERTEX;
                        end else if (r_edge_total >= EDGE_LIMIT) begin
                            n_done = 1'b1;
                            n_rsp.status = iecb_pkg::ST_PHASE;
                        end else begin
                            edge_we   = 1'b1;
                            row_re    = 1'b1;
                            out_re    = 1'b1;
                            out_raddr = r_req.source_vertex;
                            n_state   = S_ADD_IN;
                        end
                    end
                    iecb_pkg::FUNC_FINISH: begin
                        if (r_built) begin
                            n_done = 1'b1;
                            n_rsp.status = iecb_pkg::ST_PHASE;
                        end else begin
                            row_re    = 1'b1;
                            row_raddr = '0;
                            n_cnt     = '0;
                            n_sum     = '0;
                            n_state   = S_PFX;
                        end
                    end
                    iecb_pkg::FUNC_NBR, iecb_pkg::FUNC_INFO: begin
                        if (!r_built) begin
                            n_done = 1'b1;
                            n_rsp.status = iecb_pkg::ST_PHASE;
                        end else if (dst_oor) begin
                            n_done = 1'b1;
                            n_rsp.status = iecb_pkg::ST_VERTEX;
                        end else begin
                            row_re  = 1'b1;
                            out_re  = 1'b1;
                            n_state = S_Q_BASE;
                        end
                    end
                    iecb_pkg::FUNC_FLAT: begin
                        if (!r_built) begin
                            n_done = 1'b1;
                            n_rsp.status = iecb_pkg::ST_PHASE;
                        end else if (CNT_W'(r_req.position) >= r_edge_total) begin
                            n_done = 1'b1;
                            n_rsp.status = iecb_pkg::ST_POS;
                        end else begin
                            nbr_re  = 1'b1;
                            n_state = S_Q_NBR;
                        end
                    end
                    default: begin
                        n_done = 1'b1;
                        n_rsp.status = iecb_pkg::ST_PHASE;
                    end
                endcase
            end

            // bump the destination's in-degree
            S_ADD_IN: begin
                row_we    = 1'b1;
                row_waddr = r_req.dest_vertex;
                row_wdata = alu_y[CNT_W-1:0];
                n_state   = S_ADD_OUT;
            end

            // bump the source's out-degree and commit the edge
            S_ADD_OUT: begin
                out_we       = 1'b1;
                out_waddr    = r_req.source_vertex;
                out_wdata    = alu_y[CNT_W-1:0];
                n_edge_total = r_edge_total + CNT_W'(1);
                n_done       = 1'b1;
                n_rsp        = '0;
                n_state      = S_IDLE;
            end

            // exclusive prefix sum: row start and cursor of vertex r_cnt
            S_PFX: begin
                row_we    = 1'b1;
                row_wdata = r_sum;
                cur_we    = 1'b1;
                n_sum     = alu_y[CNT_W-1:0];
                n_cnt     = r_cnt + VTX_W'(1);
                if (r_cnt != LAST_VTX) begin
                    row_re    = 1'b1;
                    row_raddr = r_cnt + VTX_W'(1);
                end else if (r_edge_total == '0) begin
                    n_built = 1'b1;
                    n_done  = 1'b1;
                    n_rsp   = '0;
                    n_state = S_IDLE;
                end else begin
                    edge_re    = 1'b1;
                    edge_raddr = '0;
                    n_eidx     = '0;
                    n_state    = S_SC_C;
                end
            end

            // fetch the cursor of the current edge's destination
            S_SC_C: begin
                cur_re  = 1'b1;
                n_state = S_SC_W;
            end

            // place the source, advance the cursor, fetch the next edge
            S_SC_W: begin
                nbr_we    = (cur_rd < EDGE_LIMIT);
                cur_we    = 1'b1;
                cur_waddr = edge_rd.dst;
                cur_wdata = alu_y[CNT_W-1:0];
                if ((CNT_W'(r_eidx) + CNT_W'(1)) == r_edge_total) begin
                    n_built = 1'b1;
                    n_done  = 1'b1;
                    n_rsp   = '0;
                    n_state = S_IDLE;
                end else begin
                    edge_re    = 1'b1;
                    edge_raddr = r_eidx + EDGE_AW'(1);
                    n_eidx     = r_eidx + EDGE_AW'(1);
                    n_state    = S_SC_C;
                end
            end

            // row base and out-degree arrive; fetch the next row start
            S_Q_BASE: begin
                n_base = row_rd;
                n_outd = out_rd;
                if (r_req.dest_vertex != LAST_VTX) begin
                    row_re    = 1'b1;
                    row_raddr = r_req.dest_vertex + VTX_W'(1);
                end
                n_state = S_Q_IND;
            end

            // in-degree is the row length
            S_Q_IND: begin
                n_ind = alu_y[CNT_W-1:0];
                if (r_req.func == iecb_pkg::FUNC_INFO) begin
                    n_done           = 1'b1;
                    n_rsp            = '0;
                    n_rsp.row_base   = r_base;
                    n_rsp.in_degree  = alu_y[CNT_W-1:0];
                    n_rsp.out_degree = r_outd;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_Q_POS;
                end
            end

            // position must lie inside the row and the list
            S_Q_POS: begin
                if (CNT_W'(r_req.position) >= r_ind ||
                    alu_y >= (CNT_W + 1)'(iecb_pkg::MAX_EDGES)) begin
                    n_done       = 1'b1;
                    n_rsp        = '0;
                    n_rsp.status = iecb_pkg::ST_POS;
                    n_state      = S_IDLE;
                end else begin
                    nbr_re    = 1'b1;
                    nbr_raddr = alu_y[EDGE_AW-1:0];
                    n_state   = S_Q_NBR;
                end
            end

            // neighbor list entry arrives
            S_Q_NBR: begin
                n_done         = 1'b1;
                n_rsp          = '0;
                n_rsp.neighbor = nbr_rd;
                if (r_req.func == iecb_pkg::FUNC_NBR) begin
                    n_rsp.row_base   = r_base;
                    n_rsp.in_degree  = r_ind;
                    n_rsp.out_degree = r_outd;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_built      <= 1'b0;
            r_edge_total <= '0;
            r_cnt        <= '0;
            r_eidx       <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_built      <= n_built;
            r_edge_total <= n_edge_total;
            r_cnt        <= n_cnt;
            r_eidx       <= n_eidx;
            r_done       <= n_done;
        end
    end

    // payload registers; the request is captured when it is accepted
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_rsp  <= n_rsp;
        r_sum  <= n_sum;
        r_base <= n_base;
        r_ind  <= n_ind;
        r_outd <= n_outd;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done,
        "result strobe held for two cycles")
    `ASSERT_NEXT(a_built_sticky, i_clk, i_rst_n, r_built, r_built,
        "built flag cleared without reset")
    `ASSERT_SAME(a_total_bound, i_clk, i_rst_n, 1'b1, r_edge_total <= EDGE_LIMIT,
        "edge total beyond the edge store")
    `ASSERT_SAME(a_slot_bound, i_clk, i_rst_n, r_state == S_SC_W, cur_rd < EDGE_LIMIT,
        "scatter cursor beyond the neighbor list")

endmodule

### tb/in_edge_csr_builder_tb.sv
// self-checking testbench of the in-edge csr builder: request stream, apb setup, result checks
// depends on iecb_pkg and the in_edge_csr_builder rtl; a built-in graph predictor supplies
// the expected result of every request whose status is not typed in
module in_edge_csr_builder_tb;
    import iecb_pkg::*;

    // func codes the block does not implement
    localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    // directed table stages: before the store fills, and around the finish
    localparam int STAGE_EMPTY = 0;
    localparam int STAGE_FULL  = 1;
    localparam int KEEP_VC     = -1;

    // idle margin once the last result has come back
    localparam int SETTLE_CYCLES = 20;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    t_req                 i_req   = '0;
    logic                 o_done;
    t_rsp                 o_rsp;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    in_edge_csr_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // free-running clock, period 20
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #24000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // graph predictor state
    // ------------------------------------------------------------------
    logic [VC_W-1:0]  cfg_vertex_count = VC_RESET;
    logic [VTX_W-1:0] g_src [MAX_EDGES];
    logic [VTX_W-1:0] g_dst [MAX_EDGES];
    logic [VTX_W-1:0] g_nbrs [MAX_EDGES];
    int               g_edges;
    int               g_row [MAX_VERTICES+1];   // in-degree counts, then row starts
    int               g_outdeg [MAX_VERTICES];
    int               g_cursor [MAX_VERTICES];
    bit               g_built;

    t_rsp             csr_replies_due [$];
    int               mismatch_count = 0;
    bit               burst_mode = 1'b0;
    int               hot_dst;
    int               hot_src;

    typedef struct {
        int                stage;
        int                vc;        // new vertex count before the row, or KEEP_VC
        t_req              req;
        bit                typed;     // expected status typed in, all other fields zero
        logic [STAT_W-1:0] status;
    } dir_row_t;

    dir_row_t dir_rows [$];

    // vertex count clipped to the array size
    function automatic int live_vertices();
        return (int'(cfg_vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(cfg_vertex_count);
    endfunction

    // stable counting sort by destination: prefix sums, then scatter in arrival order
    function automatic void build_rows();
        int sum;
        int cnt;
        int slot;
        sum = 0;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            cnt         = g_row[v];
            g_row[v]    = sum;
            g_cursor[v] = sum;
            sum        += cnt;
        end
        g_row[MAX_VERTICES] = sum;
        for (int e = 0; e < g_edges; e++) begin
            slot = g_cursor[g_dst[e]];
            if (slot < MAX_EDGES) begin
                g_nbrs[slot] = g_src[e];
            end
            g_cursor[g_dst[e]] = slot + 1;
        end
        g_built = 1'b1;
    endfunction

    // result of one accepted request; updates the graph state
    function automatic t_rsp csr_reply(t_req r);
        t_rsp rsp;
        int   nv;
        int   d;
        int   s;
        int   p;
        int   base;
        int   ind;
        rsp  = '0;
        nv   = live_vertices();
        d    = int'(r.dest_vertex);
        s    = int'(r.source_vertex);
        p    = int'(r.position);
        case (r.func)
            FUNC_ADD: begin
                // wrong phase first, then vertex range, then a full store
                if (g_built) begin
                    rsp.status = ST_PHASE;
                end else if (d >= nv || s >= nv) begin
                    rsp.status = ST_VERTEX;
                end else if (g_edges >= MAX_EDGES) begin
                    rsp.status = ST_PHASE;
                end else begin
                    g_src[g_edges] = r.source_vertex;
                    g_dst[g_edges] = r.dest_vertex;
                    g_edges++;
                    g_row[d]++;
                    g_outdeg[s]++;
                end
            end
            FUNC_FINISH: begin
                if (g_built) begin
                    rsp.status = ST_PHASE;
                end else begin
                    build_rows();
                end
            end
            FUNC_NBR, FUNC_INFO: begin
                if (!g_built) begin
                    rsp.status = ST_PHASE;
                end else if (d >= nv) begin
                    rsp.status = ST_VERTEX;
                end else begin
                    base = g_row[d];
                    ind  = g_row[d+1] - base;
                    if (r.func == FUNC_INFO) begin
                        rsp.row_base   = CNT_W'(base);
                        rsp.in_degree  = CNT_W'(ind);
                        rsp.out_degree = CNT_W'(g_outdeg[d]);
                    end else if (p >= ind || base + p >= MAX_EDGES) begin
                        rsp.status = ST_POS;
                    end else begin
                        rsp.neighbor   = g_nbrs[base+p];
                        rsp.row_base   = CNT_W'(base);
                        rsp.in_degree  = CNT_W'(ind);
                        rsp.out_degree = CNT_W'(g_outdeg[d]);
                    end
                end
            end
            FUNC_FLAT: begin
                if (!g_built) begin
                    rsp.status = ST_PHASE;
                end else if (p >= g_edges) begin
                    rsp.status = ST_POS;
                end else begin
                    rsp.neighbor = g_nbrs[p];
                end
            end
            default: begin
                rsp.status = ST_PHASE;
            end
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void dir_row(int stage, int vc, logic [FUNC_W-1:0] f, int d, int s, int p,
                                    bit typed, logic [STAT_W-1:0] st);
        dir_row_t row;
        row.stage             = stage;
        row.vc                = vc;
        row.req.func          = f;
        row.req.dest_vertex   = VTX_W'(d);
        row.req.source_vertex = VTX_W'(s);
        row.req.position      = POS_W'(p);
        row.typed             = typed;
        row.status            = st;
        dir_rows.push_back(row);
    endfunction

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    // vertex below nv, skewed toward a hot vertex and the range ends
    function automatic int pick_vertex(int nv, int hot);
        int r;
        r = $urandom_range(0, 99);
        if (r < 18) begin
            return hot % nv;
        end else if (r < 21) begin
            return nv - 1;
        end else if (r < 23) begin
            return 0;
        end else begin
            return $urandom_range(0, nv - 1);
        end
    endfunction

    // build phase: mostly valid adds, some noise; never a finish
    function automatic t_req build_item();
        t_req r;
        int   nv;
        nv              = live_vertices();
        r.func          = FUNC_ADD;
        r.dest_vertex   = VTX_W'($urandom());
        r.source_vertex = VTX_W'($urandom());
        r.position      = POS_W'($urandom());
        if (nv > 0 && $urandom_range(0, 99) < 88) begin
            r.dest_vertex   = VTX_W'(pick_vertex(nv, hot_dst));
            r.source_vertex = VTX_W'(pick_vertex(nv, hot_src));
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    // one end of the edge past the vertex count
                    if (nv < MAX_VERTICES) begin
                        if ($urandom_range(0, 1) == 0) begin
                            r.dest_vertex = VTX_W'($urandom_range(nv, MAX_VERTICES - 1));
                        end else begin
                            r.source_vertex = VTX_W'($urandom_range(nv, MAX_VERTICES - 1));
                        end
                    end
                end
                1: r.func = FUNC_NBR + FUNC_W'($urandom_range(0, 2));   // query too early
                2: r.func = FUNC_SPARE_5 + FUNC_W'($urandom_range(0, 2));
                default: begin
                    r.func = FUNC_W'($urandom_range(1, 6));
                    if (r.func == FUNC_FINISH) begin
                        r.func = FUNC_SPARE_7;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // query phase: mostly valid queries, positions mostly inside the row
    function automatic t_req query_item();
        t_req r;
        int   nv;
        int   pick;
        int   d;
        int   ind;
        nv              = live_vertices();
        r.func          = FUNC_INFO;
        r.dest_vertex   = VTX_W'($urandom());
        r.source_vertex = VTX_W'($urandom());
        r.position      = POS_W'($urandom());
        pick            = $urandom_range(0, 99);
        if (nv == 0 || pick >= 88) begin
            case ($urandom_range(0, 3))
                0: begin
                    r.func = ($urandom_range(0, 1) == 0) ? FUNC_NBR : FUNC_INFO;
                    if (nv < MAX_VERTICES) begin
                        r.dest_vertex = VTX_W'($urandom_range(nv, MAX_VERTICES - 1));
                    end
                end
                1: r.func = FUNC_ADD;
                2: r.func = FUNC_FINISH;
                default: r.func = FUNC_SPARE_5 + FUNC_W'($urandom_range(0, 2));
            endcase
        end else begin
            d             = pick_vertex(nv, hot_dst);
            r.dest_vertex = VTX_W'(d);
            ind           = g_row[d+1] - g_row[d];
            if (pick < 30) begin
                r.func = FUNC_INFO;
            end else if (pick < 62) begin
                r.func = FUNC_NBR;
                if (ind > 0 && $urandom_range(0, 4) != 0) begin
                    r.position = POS_W'($urandom_range(0, ind - 1));
                end else if ($urandom_range(0, 1) == 0) begin
                    r.position = POS_W'(ind);   // first position past the row
                end
            end else begin
                r.func = FUNC_FLAT;
            end
        end
        return r;
    endfunction

    // vertex count for each build phase: extremes, saturation and random values
    function automatic logic [VC_W-1:0] build_count(int phase);
        case (phase % 8)
            0: return VC_W'(MAX_VERTICES);
            1: return VC_W'(2047);
            2: return VC_W'($urandom_range(3, MAX_VERTICES - 1));
            3: return VC_W'(1);
            4: return VC_W'(0);
            5: return VC_W'(MAX_VERTICES - 1);
            6: return VC_W'($urandom_range(MAX_VERTICES + 1, 2047));
            default: return VC_W'(2);
        endcase
    endfunction

    // one request: hold start until accepted, predict at acceptance, then maybe idle
    task automatic push_request(t_req r, bit typed = 1'b0, logic [STAT_W-1:0] st = ST_OK);
        t_rsp want;
        int   gap;
        gap   = pick_gap();
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = csr_reply(r);
        if (typed) begin
            want        = '0;
            want.status = st;
        end
        csr_replies_due.push_back(want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop requesting and wait for every outstanding result
    task automatic settle();
        start <= 1'b0;
        while (csr_replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb read of the vertex count register, compared with what was last written
    task automatic apb_read_check(logic [VC_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_VERTEX_COUNT;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== DATA_W'(want)) begin
            $display("%0t: vertex_count read expected %0d got %0h", $time, want, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // apb write with junk in the unused upper bits, then read back
    task automatic set_vertex_count(logic [VC_W-1:0] vc);
        logic [DATA_W-1:0] word;
        word            = $urandom();
        word[VC_W-1:0]  = vc;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VERTEX_COUNT;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg_vertex_count = vc;
        apb_read_check(vc);
    endtask

    task automatic run_table(int stage);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].stage == stage) begin
                if (dir_rows[i].vc != KEEP_VC) begin
                    settle();
                    set_vertex_count(VC_W'(dir_rows[i].vc));
                end
                push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].status);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // results are sampled at the edge that ends their strobe cycle
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (csr_replies_due.size() == 0) begin
                $display("%0t: result with no request waiting, expected none got %p", $time, o_rsp);
                mismatch_count++;
            end else begin
                want = csr_replies_due.pop_front();
                check_field("neighbor",   CNT_W'(want.neighbor), CNT_W'(o_rsp.neighbor));
                check_field("row_base",   want.row_base,         o_rsp.row_base);
                check_field("in_degree",  want.in_degree,        o_rsp.in_degree);
                check_field("out_degree", want.out_degree,       o_rsp.out_degree);
                check_field("status",     CNT_W'(want.status),   CNT_W'(o_rsp.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int               phase;
        int               n;
        logic [VC_W-1:0]  vc;

        hot_dst = $urandom_range(0, MAX_VERTICES - 1);
        hot_src = $urandom_range(0, MAX_VERTICES - 1);

        // empty graph: early queries, unknown funcs, add extremes, range checks
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_INFO,    0,    0,    0,    1, ST_PHASE);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_NBR,     1023, 1023, 4095, 1, ST_PHASE);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_FLAT,    0,    0,    4095, 1, ST_PHASE);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_SPARE_5, 0,    0,    0,    1, ST_PHASE);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_SPARE_7, 1023, 1023, 4095, 1, ST_PHASE);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_ADD,     0,    0,    0,    1, ST_OK);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_ADD,     1023, 1023, 4095, 1, ST_OK);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_ADD,     1023, 0,    2730, 1, ST_OK);
        // count above the array size saturates
        dir_row(STAGE_EMPTY, 2047,    FUNC_ADD,     1023, 512,  1365, 1, ST_OK);
        // zero count: every vertex out of range
        dir_row(STAGE_EMPTY, 0,       FUNC_ADD,     0,    0,    0,    1, ST_VERTEX);
        dir_row(STAGE_EMPTY, 1,       FUNC_ADD,     0,    1,    0,    1, ST_VERTEX);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_ADD,     0,    0,    0,    1, ST_OK);
        // wrong phase wins over the vertex range
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_INFO,    5,    0,    0,    1, ST_PHASE);
        dir_row(STAGE_EMPTY, 512,     FUNC_ADD,     512,  0,    0,    1, ST_VERTEX);
        dir_row(STAGE_EMPTY, KEEP_VC, FUNC_ADD,     511,  511,  0,    1, ST_OK);

        // full store: overflow, finish, second finish, add after finish, first queries
        dir_row(STAGE_FULL, 1024,    FUNC_ADD,     0,    0,    0,    1, ST_PHASE);
        // vertex range wins over a full store
        dir_row(STAGE_FULL, 4,       FUNC_ADD,     9,    0,    0,    1, ST_VERTEX);
        dir_row(STAGE_FULL, KEEP_VC, FUNC_FINISH,  0,    0,    0,    1, ST_OK);
        dir_row(STAGE_FULL, KEEP_VC, FUNC_FINISH,  1023, 1023, 4095, 1, ST_PHASE);
        dir_row(STAGE_FULL, KEEP_VC, FUNC_ADD,     0,    0,    0,    1, ST_PHASE);
        // wrong phase wins over the vertex range
        dir_row(STAGE_FULL, KEEP_VC, FUNC_ADD,     9,    9,    0,    1, ST_PHASE);
        dir_row(STAGE_FULL, KEEP_VC, FUNC_INFO,    4,    0,    0,    1, ST_VERTEX);
        dir_row(STAGE_FULL, 1024,    FUNC_INFO,    0,    0,    0,    0, ST_OK);
        dir_row(STAGE_FULL, KEEP_VC, FUNC_INFO,    1023, 0,    0,    0, ST_OK);
        dir_row(STAGE_FULL, KEEP_VC, FUNC_NBR,     0,    0,    0,    0, ST_OK);
        // position far past the row
        dir_row(STAGE_FULL, KEEP_VC, FUNC_NBR,     1023, 0,    4095, 0, ST_OK);
        dir_row(STAGE_FULL, KEEP_VC, FUNC_FLAT,    0,    0,    4095, 0, ST_OK);
        // flat entries ignore the vertex count
        dir_row(STAGE_FULL, 0,       FUNC_FLAT,    0,    0,    2048, 0, ST_OK);
        dir_row(STAGE_FULL, KEEP_VC, FUNC_NBR,     0,    0,    0,    1, ST_VERTEX);

        // hold reset, then release it; the block then clears its count memories
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_read_check(VC_RESET);

        run_table(STAGE_EMPTY);

        // fill the edge store to the last entry, phase by phase under changing counts
        phase = 0;
        while (g_edges < MAX_EDGES) begin
            vc = build_count(phase);
            settle();
            set_vertex_count(vc);
            burst_mode = ($urandom_range(0, 3) == 0);
            n = (vc < 16) ? 25 : $urandom_range(300, 600);
            for (int k = 0; k < n && g_edges < MAX_EDGES; k++) begin
                push_request(build_item());
            end
            phase++;
        end
        burst_mode = 1'b0;

        // with all MAX_EDGES stored, no 12-bit flat position lies past the end
        run_table(STAGE_FULL);

        // queries on the built graph under several counts
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: vc = VC_W'(MAX_VERTICES);
                1: vc = VC_W'($urandom_range(2, MAX_VERTICES - 1));
                2: vc = VC_W'(2047);
                3: vc = VC_W'(1);
                4: vc = VC_W'(0);
                5: vc = VC_W'(MAX_VERTICES - 1);
                default: vc = VC_W'($urandom_range(MAX_VERTICES + 1, 2047));
            endcase
            settle();
            set_vertex_count(vc);
            burst_mode = ($urandom_range(0, 3) == 0);
            n = (vc < 16) ? 20 : $urandom_range(120, 160);
            repeat (n) push_request(query_item());
        end
        burst_mode = 1'b0;

        settle();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
